// File: rtl/core/msv_pkg.sv
// Shared types and constants for the Moebius sieve block.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package msv_pkg;

  // Operation codes carried in the request opcode field
  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Response status codes
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  // Response value for builds and failed queries
  localparam logic signed [1:0] MU_NONE = 2'sd0;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;       // take the request transaction
    logic q_rd;         // read the store at the request index
    logic init_step;    // write the starting value at the sweep index, advance it
    logic outer_start;  // load the outer index with two
    logic out_rd;       // read the store at the outer index
    logic out_skip;     // advance the outer index
    logic inner_start;  // latch the divisor entry, load the multiple with twice the index
    logic in_rd;        // read the store at the multiple
    logic in_wr;        // write back the updated multiple, step to the next one
    logic load_result;  // fill the response register
  } msv_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic req_query;  // incoming transaction is a query
    logic req_bad;    // incoming transaction is out of range
    logic j_eq_n;     // sweep index reached the size
    logic j_gt_n;     // multiple passed the size
    logic i_gt_n;     // outer index passed the size
    logic rd_zero;    // entry read back is zero
    logic slot_free;  // response register can take a new result
  } msv_stat_t;

endpackage

// File: rtl/core/msv_req_if.sv
// Request channel: valid/ready handshake with opcode, size and index.
// Depends on nothing.
`timescale 1ns / 1ps

interface msv_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] size;
  logic [15:0] index;

  modport source (output valid, output opcode, output size, output index, input ready);
  modport sink   (input valid, input opcode, input size, input index, output ready);
endinterface

// File: rtl/core/msv_rsp_if.sv
// Response channel: valid/ready handshake with the Moebius value and status.
// Depends on nothing.
`timescale 1ns / 1ps

interface msv_rsp_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] mu_value;
  logic              status;

  modport source (output valid, output mu_value, output status, input ready);
  modport sink   (input valid, input mu_value, input status, output ready);
endinterface

// File: rtl/core/msv_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module msv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/msv_ctrl.sv
// Controller state machine for the Moebius sieve: sequences the build sweep,
// the sieve passes, queries and response hand-off. Depends on msv_pkg.
`timescale 1ns / 1ps

module msv_ctrl
  import msv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  msv_stat_t stat,
  output msv_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INIT    = 3'd1;
  localparam logic [2:0] S_OUT_RD  = 3'd2;
  localparam logic [2:0] S_OUT_CHK = 3'd3;
  localparam logic [2:0] S_IN_RD   = 3'd4;
  localparam logic [2:0] S_IN_WR   = 3'd5;
  localparam logic [2:0] S_RESP    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          if (stat.req_bad) begin
            state_next = S_RESP;
          end else if (stat.req_query) begin
            cmd.q_rd   = 1'b1;
            state_next = S_RESP;
          end else begin
            state_next = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (stat.j_eq_n) begin
          cmd.outer_start = 1'b1;
          state_next      = S_OUT_RD;
        end
      end
      S_OUT_RD: begin
        if (stat.i_gt_n) begin
          state_next = S_RESP;
        end else begin
          cmd.out_rd = 1'b1;
          state_next = S_OUT_CHK;
        end
      end
      S_OUT_CHK: begin
        if (stat.rd_zero) begin
          cmd.out_skip = 1'b1;
          state_next   = S_OUT_RD;
        end else begin
          cmd.inner_start = 1'b1;
          state_next      = S_IN_RD;
        end
      end
      S_IN_RD: begin
        if (stat.j_gt_n) begin
          cmd.out_skip = 1'b1;
          state_next   = S_OUT_RD;
        end else begin
          cmd.in_rd  = 1'b1;
          state_next = S_IN_WR;
        end
      end
      S_IN_WR: begin
        cmd.in_wr  = 1'b1;
        state_next = S_IN_RD;
      end
      S_RESP: begin
        if (stat.slot_free) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/core/msv_dpath.sv
// Datapath for the Moebius sieve: table store, sieve counters, table bookkeeping
// and the response register. Depends on msv_pkg and msv_ram.
`timescale 1ns / 1ps

module msv_dpath
  import msv_pkg::*;
#(
  parameter int MAX_N       = 65535,
  parameter int ENTRY_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  msv_cmd_t          cmd,
  output msv_stat_t         stat,
  input  logic              req_opcode,
  input  logic [15:0]       req_size,
  input  logic [15:0]       req_index,
  input  logic              rsp_ready,
  output logic              rsp_valid,
  output logic signed [1:0] rsp_mu_value,
  output logic              rsp_status
);

  localparam int DEPTH = MAX_N + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = (AW > 16) ? AW : 16;  // holds any size or table index
  localparam int CW    = NW + 1;               // holds a multiple up to twice the size

  logic [NW-1:0]          n;
  logic [CW-1:0]          i;
  logic [CW-1:0]          j;
  logic [ENTRY_WIDTH-1:0] d;
  logic [15:0]            built_size;
  logic                   table_valid;
  logic                   op_q;
  logic                   bad_q;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [ENTRY_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [ENTRY_WIDTH-1:0] ram_rdata;
  logic [ENTRY_WIDTH-1:0] init_val;
  logic [NW-1:0]          index_ext;
  logic                   size_bad;
  logic                   index_bad;

  // Range checks on the incoming transaction
  assign index_ext = NW'(req_index);
  assign size_bad  = {1'b0, NW'(req_size)} > CW'(MAX_N);
  assign index_bad = !table_valid || (req_index > built_size);

  assign stat.req_query = (req_opcode == OP_QUERY);
  assign stat.req_bad   = (req_opcode == OP_QUERY) ? index_bad : size_bad;
  assign stat.j_eq_n    = (j == {1'b0, n});
  assign stat.j_gt_n    = (j > {1'b0, n});
  assign stat.i_gt_n    = (i > {1'b0, n});
  assign stat.rd_zero   = (ram_rdata == '0);
  assign stat.slot_free = !rsp_valid || rsp_ready;

  // Starting entry: zero at 0, one at 1, minus one above
  always_comb begin
    if (j == '0) begin
      init_val = '0;
    end else if (j == CW'(1)) begin
      init_val = ENTRY_WIDTH'(1);
    end else begin
      init_val = '1;
    end
  end

  // Store port selection
  assign ram_we    = cmd.init_step || cmd.in_wr;
  assign ram_waddr = j[AW-1:0];
  assign ram_wdata = cmd.in_wr ? (ram_rdata - d) : init_val;
  assign ram_re    = cmd.q_rd || cmd.out_rd || cmd.in_rd;
  always_comb begin
    priority if (cmd.q_rd) begin
      ram_raddr = index_ext[AW-1:0];
    end else if (cmd.out_rd) begin
      ram_raddr = i[AW-1:0];
    end else begin
      ram_raddr = j[AW-1:0];
    end
  end

  msv_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Latch the transaction and advance the sieve counters
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= req_opcode;
      bad_q <= stat.req_bad;
      n     <= NW'(req_size);
      j     <= '0;
    end
    if (cmd.init_step) begin
      j <= j + CW'(1);
    end
    if (cmd.outer_start) begin
      i <= CW'(2);
    end
    if (cmd.out_skip) begin
      i <= i + CW'(1);
    end
    if (cmd.inner_start) begin
      d <= ram_rdata;
      j <= i + i;
    end
    if (cmd.in_wr) begin
      j <= j + i;
    end
  end

  // Table bookkeeping: commit the size of a good build
  always_ff @(posedge clk) begin
    if (rst) begin
      built_size  <= '0;
      table_valid <= 1'b0;
    end else if (cmd.accept && (req_opcode == OP_BUILD) && !size_bad) begin
      built_size  <= req_size;
      table_valid <= 1'b1;
    end
  end

  // Response register: hold until the sink takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_result) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      rsp_status <= bad_q ? ST_RANGE : ST_OK;
      if ((op_q == OP_QUERY) && !bad_q) begin
        rsp_mu_value <= ram_rdata[1:0];
      end else begin
        rsp_mu_value <= MU_NONE;
      end
    end
  end

endmodule

// File: rtl/core/mobius_sieve.sv
// Moebius function sieve: a build transaction (opcode 0, size n) fills the table
// with mu(0..n); a query transaction (opcode 1, index) reads one value back.
// Every request transaction yields exactly one response transaction.
// Status is 1 for a build whose size exceeds MAX_N, for a query before any
// build and for a query whose index exceeds the last built size; mu_value is
// then 0, as it is for every build.
// Requests are taken one at a time: ready is high only while the block idles.
// A query, or any out-of-range request, goes to the response state on acceptance;
// its result is loaded once the response register is free, and ready returns as the response goes valid.
// A build seeds the table at indices 0 to n, then visits each outer index from
// 2 to n, runs an inner loop for each squarefree index, and does a
// read-modify-write of each multiple (registered store read, then write);
// its result is then loaded like a query's.
// The response sits in an output register; while the sink stalls, the block
// finishes the current request and then waits before loading the next result.
// Synchronous reset clears the controller, the response valid and the table
// valid flag; table contents need no clearing, since only built entries are read.
// Depends on msv_pkg, msv_req_if, msv_rsp_if, msv_ctrl and msv_dpath.
`timescale 1ns / 1ps

module mobius_sieve
  import msv_pkg::*;
#(
  parameter int MAX_N       = 65535,
  parameter int ENTRY_WIDTH = 8
) (
  input logic           clk,
  input logic           rst,
  msv_req_if.sink       req,
  msv_rsp_if.source     rsp
);

  msv_cmd_t  cmd;
  msv_stat_t stat;

  msv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  msv_dpath #(
    .MAX_N       (MAX_N),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_opcode   (req.opcode),
    .req_size     (req.size),
    .req_index    (req.index),
    .rsp_ready    (rsp.ready),
    .rsp_valid    (rsp.valid),
    .rsp_mu_value (rsp.mu_value),
    .rsp_status   (rsp.status)
  );

endmodule

// File: bench/tb_top.sv
// Testbench for mobius_sieve: random and directed build/query transactions, checked
// against an in-bench sieve of the Moebius function. Depends on msv_pkg, msv_req_if,
// msv_rsp_if and the mobius_sieve RTL.
`timescale 1ns / 1ps

module tb_top;
  import msv_pkg::*;

  localparam int MAX_N      = 65535;
  localparam int ENTRY_W    = 8;
  localparam int IDLE_PCT   = 30;
  localparam int HOLD_LEN   = 400;
  localparam int HOLD_AT    = 150;
  localparam int STALL_LIMIT = 5000000;

  typedef struct packed {
    logic        opcode;
    logic [15:0] size;
    logic [15:0] index;
  } sieve_req_t;

  typedef struct packed {
    logic signed [1:0] mu_value;
    logic              status;
  } sieve_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  msv_req_if req_ch ();
  msv_rsp_if rsp_ch ();

  mobius_sieve #(
    .MAX_N      (MAX_N),
    .ENTRY_WIDTH(ENTRY_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Bench copy of the block state
  logic [ENTRY_W-1:0] mu_tab [0:MAX_N];
  int                 tab_size = 0;
  bit                 tab_built = 1'b0;

  sieve_req_t req_backlog[$];
  sieve_rsp_t mu_due[$];
  sieve_req_t on_wire;
  int         n_sent = 0;
  int         n_got = 0;
  int         errors = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  int         quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idling is switched off for one long stretch of request transactions
  function automatic bit calm_now();
    return n_sent >= 400 && n_sent < 650;
  endfunction

  // Sieve the table up to n, entries wrap at the entry width
  function automatic void sieve_fill(int n);
    logic [ENTRY_W-1:0] d;
    mu_tab[0] = '0;
    if (n >= 1) mu_tab[1] = ENTRY_W'(1);
    for (int i = 2; i <= n; i++) mu_tab[i] = '1;
    for (int i = 2; i <= n; i++) begin
      d = mu_tab[i];
      if (d != 0) begin
        for (int j = 2 * i; j <= n; j += i) mu_tab[j] = mu_tab[j] - d;
      end
    end
  endfunction

  // Expected response of one request transaction; updates the bench state
  function automatic sieve_rsp_t sieve_predict(sieve_req_t r);
    sieve_rsp_t res;
    res.mu_value = MU_NONE;
    res.status   = ST_OK;
    if (r.opcode == OP_BUILD) begin
      if (int'(r.size) > MAX_N) begin
        res.status = ST_RANGE;
      end else begin
        sieve_fill(int'(r.size));
        tab_size  = int'(r.size);
        tab_built = 1'b1;
      end
    end else begin
      if (!tab_built || int'(r.index) > tab_size || int'(r.index) > MAX_N) begin
        res.status = ST_RANGE;
      end else begin
        res.mu_value = mu_tab[r.index][1:0];
      end
    end
    return res;
  endfunction

  // Driver: offer the next pending transaction, hold it until taken
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid  <= 1'b0;
      req_ch.opcode <= OP_BUILD;
      req_ch.size   <= '0;
      req_ch.index  <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        mu_due.push_back(sieve_predict(on_wire));
        n_sent <= n_sent + 1;
      end
      if (req_ch.valid && !req_ch.ready) begin
        // hold the current transaction
      end else if (req_backlog.size() > 0 &&
                   (calm_now() || $urandom_range(99) >= IDLE_PCT)) begin
        on_wire = req_backlog.pop_front();
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= on_wire.opcode;
        req_ch.size   <= on_wire.size;
        req_ch.index  <= on_wire.index;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: check each response transaction, drive ready with stalls
  always @(posedge clk) begin
    sieve_rsp_t want;
    int         got_now;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      got_now = n_got;
      if (rsp_ch.valid && rsp_ch.ready) begin
        got_now = n_got + 1;
        n_got <= got_now;
        if (mu_due.size() == 0) begin
          errors++;
          $display("%0t unexpected response: mu_value %0d status %0d", $time,
                   rsp_ch.mu_value, rsp_ch.status);
        end else begin
          want = mu_due.pop_front();
          if (rsp_ch.mu_value !== want.mu_value) begin
            errors++;
            $display("%0t mu_value mismatch: expected %0d actual %0d", $time,
                     want.mu_value, rsp_ch.mu_value);
          end
          if (rsp_ch.status !== want.status) begin
            errors++;
            $display("%0t status mismatch: expected %0d actual %0d", $time,
                     want.status, rsp_ch.status);
          end
        end
      end
      // One long hold-off so the block backs up into the request side
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_ch.ready <= 1'b0;
      end else if (!hold_done && got_now == HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= calm_now() || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: stop when no transaction moves for too long
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(logic op, int sz, int ix);
    sieve_req_t r;
    r.opcode = op;
    r.size   = sz[15:0];
    r.index  = ix[15:0];
    req_backlog.push_back(r);
  endtask

  task automatic wait_drained();
    while (req_backlog.size() != 0 || req_ch.valid || mu_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    int gen_n;
    int pick;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: queries before any build, tiny tables, the full table
    push_item(OP_QUERY, $urandom, 0);
    push_item(OP_QUERY, $urandom, 65535);
    push_item(OP_BUILD, 0, $urandom);
    push_item(OP_QUERY, $urandom, 0);
    push_item(OP_QUERY, $urandom, 1);
    push_item(OP_BUILD, 1, $urandom);
    push_item(OP_QUERY, $urandom, 1);
    push_item(OP_QUERY, $urandom, 2);
    push_item(OP_BUILD, 2, $urandom);
    push_item(OP_QUERY, $urandom, 2);
    push_item(OP_BUILD, 30, $urandom);
    push_item(OP_QUERY, $urandom, 30);
    push_item(OP_QUERY, $urandom, 12);
    push_item(OP_QUERY, $urandom, 31);
    push_item(OP_BUILD, 65535, $urandom);
    push_item(OP_QUERY, $urandom, 65535);
    push_item(OP_QUERY, $urandom, 65534);
    push_item(OP_QUERY, $urandom, 32768);
    push_item(OP_QUERY, $urandom, 0);
    push_item(OP_QUERY, $urandom, 1);
    push_item(OP_QUERY, $urandom, 65521);
    push_item(OP_BUILD, 10, $urandom);
    push_item(OP_QUERY, $urandom, 65535);
    push_item(OP_QUERY, $urandom, 10);

    // Sender pause: let every response come back
    wait_drained();

    // Random: mostly small builds followed by queries inside the table, with some beyond it
    gen_n = 10;
    for (int k = 0; k < 950; k++) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        pick = $urandom_range(99);
        if (pick < 70)      gen_n = $urandom_range(64, 0);
        else if (pick < 95) gen_n = $urandom_range(600, 65);
        else                gen_n = $urandom_range(3000, 601);
        push_item(OP_BUILD, gen_n, $urandom);
      end else if (pick < 80) begin
        push_item(OP_QUERY, $urandom, $urandom_range(gen_n, 0));
      end else if (pick < 90) begin
        push_item(OP_QUERY, $urandom, gen_n + 1 + $urandom_range(3, 0));
      end else begin
        push_item(OP_QUERY, $urandom, $urandom_range(65535, 0));
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && mu_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/msv_pkg.sv
rtl/core/msv_req_if.sv
rtl/core/msv_rsp_if.sv
rtl/core/msv_ram.sv
rtl/core/msv_ctrl.sv
rtl/core/msv_dpath.sv
rtl/core/mobius_sieve.sv
bench/tb_top.sv
